// File: hdl/char_lcd_nibble_sequencer_top_macros.svh
// Assertion macros shared by the character LCD nibble sequencer.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLNS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("clns assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("clns assertion failed");

// Delayed implication, disabled while reset is asserted.
`define CLNS_ASSERT_LATER(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
		else $error("clns assertion failed");

`endif

// File: hdl/clns_pkg.sv
// Types, constants and the init nibble table of the character LCD nibble sequencer.
`default_nettype none

package clns_pkg;

	localparam int STEP_W = 4;

	typedef enum logic [1:0] {
		OP_INIT = 2'd0,
		OP_CMD  = 2'd1,
		OP_DATA = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_STROBE_WAIT    = 2'd0,
		REG_WRITE_WAIT     = 2'd1,
		REG_POWER_WAIT     = 2'd2,
		REG_INIT_STEP_WAIT = 2'd3
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic [3:0]  nibble;
		logic        reg_select;
		logic [15:0] wait_before;
		logic [15:0] pulse_wait;
		logic [17:0] wait_after;
		logic        last;
	} res_t;

	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic final_step;
	} status_t;

	localparam logic [15:0] STROBE_WAIT_RST    = 16'd2000;
	localparam logic [15:0] WRITE_WAIT_RST     = 16'd10000;
	localparam logic [15:0] POWER_WAIT_RST     = 16'd15000;
	localparam logic [15:0] INIT_STEP_WAIT_RST = 16'd20000;

	localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 4'd1;
	localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 4'd13;
	localparam logic [STEP_W-1:0] INIT_FIRST_CMD  = 4'd4;

	localparam logic [3:0] INIT_NIB_WAKE = 4'h3;
	localparam logic [3:0] INIT_NIB_4BIT = 4'h2;

	localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;

	// Nibble driven at each step of the power-up run.
	function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
		logic [3:0] nib;
		case (step)
			4'd0, 4'd1, 4'd2: nib = INIT_NIB_WAKE;
			4'd3:  nib = INIT_NIB_4BIT;
			4'd4:  nib = CMD_FUNCTION_SET[7:4];
			4'd5:  nib = CMD_FUNCTION_SET[3:0];
			4'd6:  nib = CMD_DISPLAY_OFF[7:4];
			4'd7:  nib = CMD_DISPLAY_OFF[3:0];
			4'd8:  nib = CMD_CLEAR[7:4];
			4'd9:  nib = CMD_CLEAR[3:0];
			4'd10: nib = CMD_ENTRY_MODE[7:4];
			4'd11: nib = CMD_ENTRY_MODE[3:0];
			4'd12: nib = CMD_DISPLAY_ON[7:4];
			4'd13: nib = CMD_DISPLAY_ON[3:0];
			default: nib = 4'h0;
		endcase
		return nib;
	endfunction

endpackage

`default_nettype wire

// File: hdl/clns_ctrl.sv
// Controller state machine of the character LCD nibble sequencer.
`default_nettype none

module clns_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  clns_pkg::op_t               op,
	input  clns_pkg::status_t           status,
	output clns_pkg::cmd_t              cmd,
	output logic                        busy
);

	clns_pkg::ctrl_state_t state_q;
	clns_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clns_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		case (state_q)
			clns_pkg::ST_IDLE: begin
				// An unused op code is taken and dropped without a run.
				if (start && (op != clns_pkg::OP_NONE)) begin
					cmd.load = 1'b1;
					state_d  = clns_pkg::ST_RUN;
				end
			end
			clns_pkg::ST_RUN: begin
				cmd.step = 1'b1;
				if (status.final_step) begin
					state_d = clns_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = clns_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q == clns_pkg::ST_RUN);

endmodule

`default_nettype wire

// File: hdl/clns_datapath.sv
// Datapath of the character LCD nibble sequencer: timing registers, step counter, result register.
`default_nettype none

module clns_datapath (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  clns_pkg::cmd_t              cmd,
	input  clns_pkg::req_t              req,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [15:0]            cfg_data,
	output clns_pkg::status_t           status,
	output clns_pkg::res_t              res,
	output logic                        strobe
);

	logic [15:0] strobe_wait_q;
	logic [15:0] write_wait_q;
	logic [15:0] power_wait_q;
	logic [15:0] init_step_wait_q;

	logic                          init_mode_q;
	logic                          rs_q;
	logic [7:0]                    value_q;
	logic [clns_pkg::STEP_W-1:0]   step_q;
	clns_pkg::res_t                res_q;
	logic                          strobe_q;

	clns_pkg::res_t res_d;
	logic           final_step;
	logic           init_cmd_step;
	logic           add_power;
	logic           add_write;
	logic           add_init;
	logic [17:0]    extra_a;
	logic [17:0]    extra_b;
	logic [17:0]    extra_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_wait_q    <= clns_pkg::STROBE_WAIT_RST;
			write_wait_q     <= clns_pkg::WRITE_WAIT_RST;
			power_wait_q     <= clns_pkg::POWER_WAIT_RST;
			init_step_wait_q <= clns_pkg::INIT_STEP_WAIT_RST;
		end else if (cfg_we) begin
			case (clns_pkg::reg_idx_t'(cfg_index))
				clns_pkg::REG_STROBE_WAIT:    strobe_wait_q    <= cfg_data;
				clns_pkg::REG_WRITE_WAIT:     write_wait_q     <= cfg_data;
				clns_pkg::REG_POWER_WAIT:     power_wait_q     <= cfg_data;
				clns_pkg::REG_INIT_STEP_WAIT: init_step_wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_mode_q <= 1'b0;
			rs_q        <= 1'b0;
			step_q      <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= cmd.step;
			if (cmd.load) begin
				init_mode_q <= (req.op == clns_pkg::OP_INIT);
				rs_q        <= (req.op == clns_pkg::OP_DATA);
				step_q      <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= req.value;
		end
		if (cmd.step) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		final_step    = init_mode_q ? (step_q == clns_pkg::INIT_LAST_STEP)
		                            : (step_q == clns_pkg::BYTE_LAST_STEP);
		// Odd steps of the command part of the init run close a byte.
		init_cmd_step = init_mode_q && (step_q >= clns_pkg::INIT_FIRST_CMD) && step_q[0];
		add_power     = init_mode_q && (step_q < clns_pkg::INIT_FIRST_CMD) && !step_q[1];
		add_write     = init_cmd_step || (!init_mode_q && final_step);
		add_init      = init_cmd_step;

		extra_a = add_power ? {2'b00, power_wait_q}     : '0;
		extra_b = add_write ? {2'b00, write_wait_q}     : '0;
		extra_c = add_init  ? {2'b00, init_step_wait_q} : '0;

		res_d.nibble      = init_mode_q ? clns_pkg::init_nibble(step_q)
		                                : (step_q[0] ? value_q[3:0] : value_q[7:4]);
		res_d.reg_select  = init_mode_q ? 1'b0 : rs_q;
		res_d.wait_before = (init_mode_q && (step_q == '0)) ? power_wait_q : '0;
		res_d.pulse_wait  = strobe_wait_q;
		res_d.wait_after  = {2'b00, strobe_wait_q} + extra_a + extra_b + extra_c;
		res_d.last        = final_step;
	end

	assign status.final_step = final_step;
	assign res               = res_q;
	assign strobe            = strobe_q;

endmodule

`default_nettype wire

// File: hdl/char_lcd_nibble_sequencer_top.sv
// Top level of the character LCD nibble sequencer.
`default_nettype none
`include "char_lcd_nibble_sequencer_top_macros.svh"

// Turns requests into enable strobe descriptions for a 4-bit character LCD bus.
// A request transaction is taken at a rising edge with start high and busy low.
// req.op selects an init run (14 strobes), a command byte or a data byte (2
// strobes each); op code 3 is taken and produces nothing.
// Each strobe description appears on res for exactly one cycle with strobe
// high; the accepting edge loads the step counter, and the first one is
// registered into res from step zero while the rest come one per cycle.
// The rate is set by the single step counter in the datapath, which
// produces one strobe per cycle.
// busy stays high while strobes are still being generated and falls as the
// final strobe (res.last high) is presented, so a new request can be taken
// at the rising edge that ends that cycle.
// The receiver cannot stall: every strobe description is consumed when shown.
// The four timing registers are written on the cfg channel, which is always
// ready; write them only while busy is low.
// Reset returns the controller to idle, clears strobe and loads the timing
// registers with their power-on defaults.

module char_lcd_nibble_sequencer_top (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  clns_pkg::req_t       req,
	output logic                 strobe,
	output clns_pkg::res_t       res,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [15:0]     cfg_data
);

	clns_pkg::cmd_t    cmd;
	clns_pkg::status_t status;
	logic              cfg_we;

	// The timing registers accept a write in any cycle.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	clns_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (req.op),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	clns_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.res       (res),
		.strobe    (strobe)
	);

	// A real request shows its first strobe once the step counter is loaded and the first result registered.
	`CLNS_ASSERT_LATER(a_first_strobe, clk, arst_n, start && !busy && (req.op != clns_pkg::OP_NONE), strobe)

	// An unused op code leaves the block idle and silent.
	`CLNS_ASSERT_NEXT(a_drop_unused, clk, arst_n, start && !busy && (req.op == clns_pkg::OP_NONE), !strobe && !busy)

	// More strobes are pending whenever a non-final strobe is shown.
	`CLNS_ASSERT_SAME(a_more_pending, clk, arst_n, strobe && !res.last, busy)

	// Only the first strobe of an init run carries a delay before enable.
	`CLNS_ASSERT_SAME(a_before_init, clk, arst_n, strobe && (res.wait_before != 16'd0), !res.reg_select && !res.last)

endmodule

`default_nettype wire

// File: sim/tb_char_lcd_nibble_sequencer_top.sv
// Testbench for the character LCD nibble sequencer: directed and random requests checked against a strobe predictor.
`timescale 1ns / 1ps

module tb_char_lcd_nibble_sequencer_top;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int REPORT_LIMIT  = 10;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_ITEMS   = 23;

	// Keeps a private copy of the timing registers, predicts the strobe
	// descriptions that each accepted request must produce, and checks the
	// strobes seen on the result port against them in order.
	class lcd_strobe_checker;
		logic [15:0]     strobe_wait;
		logic [15:0]     write_wait;
		logic [15:0]     power_wait;
		logic [15:0]     init_step_wait;
		clns_pkg::res_t  expected_strobes[$];
		int              errors;
		int              strobes_checked;
		int              init_runs;
		int              cmd_bytes;
		int              data_bytes;
		int              unused_ops;

		function new();
			strobe_wait     = clns_pkg::STROBE_WAIT_RST;
			write_wait      = clns_pkg::WRITE_WAIT_RST;
			power_wait      = clns_pkg::POWER_WAIT_RST;
			init_step_wait  = clns_pkg::INIT_STEP_WAIT_RST;
			errors          = 0;
			strobes_checked = 0;
			init_runs       = 0;
			cmd_bytes       = 0;
			data_bytes      = 0;
			unused_ops      = 0;
		endfunction

		function void set_register(clns_pkg::reg_idx_t idx, logic [15:0] value);
			case (idx)
				clns_pkg::REG_STROBE_WAIT:    strobe_wait = value;
				clns_pkg::REG_WRITE_WAIT:     write_wait = value;
				clns_pkg::REG_POWER_WAIT:     power_wait = value;
				clns_pkg::REG_INIT_STEP_WAIT: init_step_wait = value;
				default: ;
			endcase
		endfunction

		function void add_strobe(logic [3:0] nib, logic rs, logic [15:0] lead_wait,
				logic [17:0] after, logic is_last);
			clns_pkg::res_t s;
			s.nibble      = nib;
			s.reg_select  = rs;
			s.wait_before = lead_wait;
			s.pulse_wait  = strobe_wait;
			s.wait_after  = after;
			s.last        = is_last;
			expected_strobes.push_back(s);
		endfunction

		// Works out every strobe of one accepted request.
		function void note_request(clns_pkg::req_t r);
			logic [7:0]  init_cmds [5];
			logic [3:0]  wake_nibs [4];
			logic        rs;
			logic [17:0] byte_tail;
			logic [17:0] init_tail;
			init_cmds = '{clns_pkg::CMD_FUNCTION_SET, clns_pkg::CMD_DISPLAY_OFF,
				clns_pkg::CMD_CLEAR, clns_pkg::CMD_ENTRY_MODE, clns_pkg::CMD_DISPLAY_ON};
			wake_nibs = '{clns_pkg::INIT_NIB_WAKE, clns_pkg::INIT_NIB_WAKE,
				clns_pkg::INIT_NIB_WAKE, clns_pkg::INIT_NIB_4BIT};
			byte_tail = 18'(strobe_wait) + 18'(write_wait);
			init_tail = byte_tail + 18'(init_step_wait);
			case (r.op)
				clns_pkg::OP_CMD, clns_pkg::OP_DATA: begin
					rs = (r.op == clns_pkg::OP_DATA);
					if (rs)
						data_bytes++;
					else
						cmd_bytes++;
					add_strobe(r.value[7:4], rs, 16'd0, 18'(strobe_wait), 1'b0);
					add_strobe(r.value[3:0], rs, 16'd0, byte_tail, 1'b1);
				end
				clns_pkg::OP_INIT: begin
					init_runs++;
					// Wake-up nibbles: only the first waits for power, and the
					// first two carry the power delay after them as well.
					for (int i = 0; i < 4; i++)
						add_strobe(wake_nibs[i], 1'b0, (i == 0) ? power_wait : 16'd0,
							18'(strobe_wait) + ((i < 2) ? 18'(power_wait) : 18'd0), 1'b0);
					for (int i = 0; i < 5; i++) begin
						add_strobe(init_cmds[i][7:4], 1'b0, 16'd0, 18'(strobe_wait), 1'b0);
						add_strobe(init_cmds[i][3:0], 1'b0, 16'd0, init_tail, i == 4);
					end
				end
				default: unused_ops++;
			endcase
		endfunction

		function string describe(clns_pkg::res_t s);
			return $sformatf("nib=%h rs=%b before=%0d pulse=%0d after=%0d last=%b",
				s.nibble, s.reg_select, s.wait_before, s.pulse_wait, s.wait_after, s.last);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("MISMATCH at %0t: %s", $time, msg);
		endfunction

		function void check_strobe(clns_pkg::res_t got);
			clns_pkg::res_t want;
			if (expected_strobes.size() == 0) begin
				flag({"strobe with nothing outstanding: ", describe(got)});
				return;
			end
			want = expected_strobes.pop_front();
			strobes_checked++;
			if (got.nibble !== want.nibble || got.reg_select !== want.reg_select ||
					got.wait_before !== want.wait_before || got.pulse_wait !== want.pulse_wait ||
					got.wait_after !== want.wait_after || got.last !== want.last)
				flag({"expected ", describe(want), " got ", describe(got)});
		endfunction

		function void close_out();
			while (expected_strobes.size() != 0)
				flag({"strobe never seen: ", describe(expected_strobes.pop_front())});
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic            busy;
	clns_pkg::req_t  req = '0;
	logic            strobe;
	clns_pkg::res_t  res;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [1:0]      cfg_index = '0;
	logic [15:0]     cfg_data = '0;

	bit          steady = 1'b0;
	int unsigned cycle_count = 0;
	int          settings_applied = 0;
	lcd_strobe_checker board = new();

	char_lcd_nibble_sequencer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.strobe(strobe),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d strobes outstanding.", cycle_count,
				board.expected_strobes.size());
			$display("tb_char_lcd_nibble_sequencer_top: done, errors");
			$finish;
		end
	end

	// Signals read at the rising edge hold their values from before the edge,
	// so each strobe is checked in the cycle that the edge ends.
	always @(posedge clk) begin
		if (arst_n && strobe)
			board.check_strobe(res);
	end

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < 38);
	endfunction

	// Offers one request and notes it at the edge where it is taken.
	task automatic issue_request(input clns_pkg::req_t r);
		while (take_break()) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		board.note_request(r);
	endtask

	task automatic send(input clns_pkg::op_t op, input logic [7:0] value);
		clns_pkg::req_t r;
		r.op = op;
		r.value = value;
		issue_request(r);
	endtask

	// An unused op code yields no strobe, so a few extra cycles pass once the
	// last expected strobe is in before the block counts as idle.
	task automatic wait_for_quiet();
		start <= 1'b0;
		do @(posedge clk); while (board.expected_strobes.size() != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input clns_pkg::reg_idx_t idx, input logic [15:0] value);
		while (take_break()) begin
			cfg_valid <= 1'b0;
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_register(idx, value);
	endtask

	task automatic apply_settings(input logic [15:0] sw, input logic [15:0] ww,
			input logic [15:0] pw, input logic [15:0] iw);
		wait_for_quiet();
		write_register(clns_pkg::REG_STROBE_WAIT, sw);
		write_register(clns_pkg::REG_WRITE_WAIT, ww);
		write_register(clns_pkg::REG_POWER_WAIT, pw);
		write_register(clns_pkg::REG_INIT_STEP_WAIT, iw);
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	// Mostly well-formed command and data bytes, with init runs mixed in and a
	// few requests on the unused op code.
	function automatic clns_pkg::req_t random_request();
		clns_pkg::req_t r;
		int             roll;
		roll = $urandom_range(99);
		if (roll < 12)
			r.op = clns_pkg::OP_INIT;
		else if (roll < 52)
			r.op = clns_pkg::OP_CMD;
		else if (roll < 92)
			r.op = clns_pkg::OP_DATA;
		else
			r.op = clns_pkg::OP_NONE;
		r.value = 8'($urandom);
		return r;
	endfunction

	function automatic logic [15:0] random_wait();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15)
			return 16'h0000;
		if (roll < 30)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Power-on register values, byte extremes, and init runs with the
		// value field both clear and set.
		send(clns_pkg::OP_INIT, 8'hFF);
		send(clns_pkg::OP_CMD, 8'h00);
		send(clns_pkg::OP_CMD, 8'hFF);
		send(clns_pkg::OP_DATA, 8'h00);
		send(clns_pkg::OP_DATA, 8'hFF);
		send(clns_pkg::OP_DATA, 8'hA5);
		send(clns_pkg::OP_CMD, 8'h5A);
		send(clns_pkg::OP_NONE, 8'hFF);
		send(clns_pkg::OP_NONE, 8'h00);
		send(clns_pkg::OP_INIT, 8'h00);

		// All delays zero.
		apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send(clns_pkg::OP_INIT, 8'h5A);
		send(clns_pkg::OP_CMD, 8'hFF);
		send(clns_pkg::OP_DATA, 8'h0F);
		send(clns_pkg::OP_NONE, 8'hAA);

		// All delays at their maximum, which drives the longest wait_after.
		apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(clns_pkg::OP_INIT, 8'h00);
		send(clns_pkg::OP_DATA, 8'hF0);
		send(clns_pkg::OP_CMD, 8'h81);
		send(clns_pkg::OP_NONE, 8'h55);
		send(clns_pkg::OP_INIT, 8'hFF);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				apply_settings(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
			else
				apply_settings(random_wait(), random_wait(), random_wait(), random_wait());
			// One phase offers its requests with no idle cycles on the request channel.
			steady = (p == 2);
			for (int i = 0; i < PHASE_ITEMS; i++)
				issue_request(random_request());
		end
		steady = 1'b0;

		wait_for_quiet();
		board.close_out();
		$display("Covered %0d init runs, %0d command bytes, %0d data bytes, %0d unused-op requests",
			board.init_runs, board.cmd_bytes, board.data_bytes, board.unused_ops);
		$display("over %0d register settings; %0d strobes checked, %0d errors.",
			settings_applied + 1, board.strobes_checked, board.errors);
		if (board.errors == 0)
			$display("tb_char_lcd_nibble_sequencer_top: done, clean");
		else
			$display("tb_char_lcd_nibble_sequencer_top: done, errors");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/clns_pkg.sv
hdl/clns_ctrl.sv
hdl/clns_datapath.sv
hdl/char_lcd_nibble_sequencer_top.sv
sim/tb_char_lcd_nibble_sequencer_top.sv
